FILE: hdl/xsrd_pkg.sv
// Package for the XOR sprite row draw block: field widths, request kind codes,
// screen constants, the lane result type and the coordinate wrap table builder.
// Depends on nothing; every other file of the block but xsrd_ram imports it.
`default_nettype none

package xsrd_pkg;

  // Widths of the request and result fields.
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned OFFSET_W = 4;
  localparam int unsigned SPRITE_W = 8;
  localparam int unsigned LINE_W   = 5;
  localparam int unsigned ROW_W    = 64;

  // Column and wrapped coordinate widths.
  localparam int unsigned COL_W    = 6;
  localparam int unsigned TARGET_W = 7;

  // Screen geometry. Row storage is always ROW_W bits wide.
  localparam int unsigned SCREEN_WIDTH        = 64;
  localparam int unsigned SCREEN_HEIGHT_DEF   = 32;
  localparam int unsigned MAX_SPRITE_ROWS     = 16;
  localparam int unsigned NUM_LANES           = SPRITE_W;
  localparam int unsigned WRAP_ENTRIES        = 1 << POS_W;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  // What one lane found: its pixel toggle mask and whether it erased a lit pixel.
  typedef struct packed {
    logic             hit;
    logic [ROW_W-1:0] mask;
  } lane_res_t;

  typedef logic [WRAP_ENTRIES-1:0][COL_W-1:0] wrap_tab_t;

  // Builds the table v -> v mod modulus for every 8-bit coordinate by counting,
  // so it is settled entirely at elaboration.
  function automatic wrap_tab_t wrap_table(input int unsigned modulus);
    wrap_tab_t   tab;
    int unsigned cnt;
    cnt = 0;
    for (int unsigned v = 0; v < WRAP_ENTRIES; v++) begin
      tab[v] = COL_W'(cnt);
      cnt = (cnt + 1 == modulus) ? 0 : cnt + 1;
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/xsrd_in_if.sv
// Request channel of the XOR sprite row draw block: valid/ready plus the request fields.
// Depends on xsrd_pkg for the field widths.
`default_nettype none

interface xsrd_in_if
  import xsrd_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [POS_W-1:0]    x_position;
  logic [POS_W-1:0]    y_position;
  logic [OFFSET_W-1:0] row_offset;
  logic [SPRITE_W-1:0] sprite_bits;
  logic [LINE_W-1:0]   read_line;

  modport source (
    output valid, kind, x_position, y_position, row_offset, sprite_bits, read_line,
    input  ready
  );

  modport sink (
    input  valid, kind, x_position, y_position, row_offset, sprite_bits, read_line,
    output ready
  );
endinterface

`default_nettype wire

FILE: hdl/xsrd_out_if.sv
// Result channel of the XOR sprite row draw block: valid/ready plus the result fields.
// Depends on xsrd_pkg for the field widths.
`default_nettype none

interface xsrd_out_if
  import xsrd_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             collision;
  logic [ROW_W-1:0] row_pixels;

  modport source (
    output valid, collision, row_pixels,
    input  ready
  );

  modport sink (
    input  valid, collision, row_pixels,
    output ready
  );
endinterface

`default_nettype wire

FILE: hdl/xsrd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module xsrd_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/xsrd_lane.sv
// One drawing lane: places one sprite bit on its screen column, clips it at the
// right edge and checks it against the old pixel. Depends on xsrd_pkg.
`default_nettype none

module xsrd_lane
  import xsrd_pkg::*;
#(
  parameter int unsigned LANE = 0
) (
  input  wire logic [COL_W-1:0] x_start_i,
  input  wire logic             sprite_bit_i,
  input  wire logic [ROW_W-1:0] old_row_i,
  output lane_res_t             res_o
);

  logic [TARGET_W-1:0] col;
  logic [COL_W-1:0]    bit_pos;
  logic                lit;

  always_comb begin
    col     = TARGET_W'(x_start_i) + TARGET_W'(LANE);
    // Column c lives at bit 63 - c of the row word.
    bit_pos = COL_W'(ROW_W - 1) - col[COL_W-1:0];
    lit     = sprite_bit_i && (col < TARGET_W'(SCREEN_WIDTH));
    res_o.mask = lit ? (ROW_W'(1) << bit_pos) : '0;
    res_o.hit  = lit && old_row_i[bit_pos];
  end

endmodule

`default_nettype wire

FILE: hdl/xsrd_merge.sv
// Merging stage: combines the lane masks into one row toggle mask and the lane
// hits into one collision flag. Depends on xsrd_pkg.
`default_nettype none

module xsrd_merge
  import xsrd_pkg::*;
(
  input  wire lane_res_t [NUM_LANES-1:0] lanes_i,
  output lane_res_t                      merged_o
);

  always_comb begin
    merged_o = '0;
    for (int unsigned i = 0; i < NUM_LANES; i++) begin
      merged_o.mask = merged_o.mask | lanes_i[i].mask;
      merged_o.hit  = merged_o.hit  | lanes_i[i].hit;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/xor_sprite_row_draw.sv
// XOR sprite row draw: a monochrome frame store of SCREEN_HEIGHT rows of 64 pixels.
// Requests arrive on req_i (valid/ready); every request yields exactly one result
// on res_o, carrying the collision flag after the request and, for a read, the row.
// Kinds: clear blanks the frame, draw XORs one sprite byte into one row, read
// returns one row (bit 63 is column 0). Other kinds change nothing.
// Clear, skipped draws and unused kinds answer straight from the idle state; a draw
// that lands on screen and a read of a valid line pass through ST_DRAW or ST_READ,
// as the frame RAM read is registered: the row is read first, then the eight lanes
// are merged and the row written back, or for a read the row is returned.
// A request is taken only while the block is idle and the result register is free
// or being emptied in the same cycle, so a stalled receiver holds the result and
// backs up the request side; nothing is dropped.
// Reset clears the per-row valid bits and the collision flag, so the frame reads
// blank at once; there is no clearing pass. Clear also just drops the valid bits.
// Depends on xsrd_pkg, xsrd_in_if, xsrd_out_if, xsrd_ram, xsrd_lane, xsrd_merge.
`default_nettype none

module xor_sprite_row_draw
  import xsrd_pkg::*;
#(
  parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  xsrd_in_if.sink    req_i,
  xsrd_out_if.source res_o
);

  localparam int unsigned AW = $clog2(SCREEN_HEIGHT);
  localparam wrap_tab_t X_WRAP = wrap_table(SCREEN_WIDTH);
  localparam wrap_tab_t Y_WRAP = wrap_table(SCREEN_HEIGHT);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW,
    ST_READ
  } state_e;

  state_e                   state_q, state_d;
  logic                     out_vld_q, out_vld_d;
  logic                     out_col_q, out_col_d;
  logic [ROW_W-1:0]         out_pix_q, out_pix_d;
  logic                     coll_q, coll_d;
  logic [SCREEN_HEIGHT-1:0] valid_q, valid_d;

  // Request payload held for the ST_DRAW or ST_READ state.
  logic [AW-1:0]       addr_q;
  logic [COL_W-1:0]    x_start_q;
  logic [SPRITE_W-1:0] bits_q;
  logic                load;

  logic                accept;
  logic [COL_W-1:0]    y_start;
  logic [TARGET_W-1:0] target_row;
  logic                coll_new;

  logic             ram_we;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [ROW_W-1:0] ram_rdata;
  logic [ROW_W-1:0] old_row;

  lane_res_t [NUM_LANES-1:0] lane_res;
  lane_res_t                 merged;

  assign req_i.ready = (state_q == ST_IDLE) && (!out_vld_q || res_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  assign y_start    = Y_WRAP[req_i.y_position];
  assign target_row = TARGET_W'(y_start) + TARGET_W'(req_i.row_offset);

  // A row that was never written since reset or the last clear reads as blank.
  assign old_row = valid_q[addr_q] ? ram_rdata : '0;

  xsrd_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SCREEN_HEIGHT)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (old_row ^ merged.mask),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // One lane per sprite bit; lane i handles bit 7 - i, the i-th pixel from the left.
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    xsrd_lane #(
      .LANE (g)
    ) u_lane (
      .x_start_i    (x_start_q),
      .sprite_bit_i (bits_q[NUM_LANES-1-g]),
      .old_row_i    (old_row),
      .res_o        (lane_res[g])
    );
  end

  xsrd_merge u_merge (
    .lanes_i  (lane_res),
    .merged_o (merged)
  );

  always_comb begin
    state_d   = state_q;
    out_vld_d = out_vld_q && !res_o.ready;
    out_col_d = out_col_q;
    out_pix_d = out_pix_q;
    coll_d    = coll_q;
    valid_d   = valid_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = AW'(target_row);
    load      = 1'b0;
    coll_new  = coll_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_i.kind)
            KIND_CLEAR: begin
              valid_d   = '0;
              out_vld_d = 1'b1;
              out_col_d = coll_q;
              out_pix_d = '0;
            end
            KIND_DRAW: begin
              if ((OFFSET_W + 1)'(req_i.row_offset) < (OFFSET_W + 1)'(MAX_SPRITE_ROWS)) begin
                // A new sprite starts at row offset zero and clears the flag,
                // even when its rows fall off the bottom.
                coll_new = (req_i.row_offset == '0) ? 1'b0 : coll_q;
                coll_d   = coll_new;
              end
              if (((OFFSET_W + 1)'(req_i.row_offset) < (OFFSET_W + 1)'(MAX_SPRITE_ROWS))
                  && (target_row < TARGET_W'(SCREEN_HEIGHT))) begin
                ram_re  = 1'b1;
                load    = 1'b1;
                state_d = ST_DRAW;
              end else begin
                out_vld_d = 1'b1;
                out_col_d = coll_new;
                out_pix_d = '0;
              end
            end
            KIND_READ: begin
              ram_raddr = AW'(TARGET_W'(req_i.read_line));
              if (TARGET_W'(req_i.read_line) < TARGET_W'(SCREEN_HEIGHT)) begin
                ram_re  = 1'b1;
                load    = 1'b1;
                state_d = ST_READ;
              end else begin
                out_vld_d = 1'b1;
                out_col_d = coll_q;
                out_pix_d = '0;
              end
            end
            default: begin
              out_vld_d = 1'b1;
              out_col_d = coll_q;
              out_pix_d = '0;
            end
          endcase
        end
      end
      ST_DRAW: begin
        ram_we           = 1'b1;
        valid_d[addr_q]  = 1'b1;
        coll_d           = coll_q | merged.hit;
        out_vld_d        = 1'b1;
        out_col_d        = coll_q | merged.hit;
        out_pix_d        = '0;
        state_d          = ST_IDLE;
      end
      ST_READ: begin
        out_vld_d = 1'b1;
        out_col_d = coll_q;
        out_pix_d = old_row;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      out_col_q <= 1'b0;
      out_pix_q <= '0;
      coll_q    <= 1'b0;
      valid_q   <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      out_col_q <= out_col_d;
      out_pix_q <= out_pix_d;
      coll_q    <= coll_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      addr_q    <= ram_raddr;
      x_start_q <= X_WRAP[req_i.x_position];
      bits_q    <= req_i.sprite_bits;
    end
  end

  assign res_o.valid      = out_vld_q;
  assign res_o.collision  = out_col_q;
  assign res_o.row_pixels = out_pix_q;

`ifndef ASSERT_OFF
  // The result register is always free while a RAM access is in flight.
  a_busy_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !out_vld_q)
    else $error("result register occupied during a frame access");

  // ST_DRAW always delivers a result and returns to idle.
  a_draw_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAW) |=> (out_vld_q && (state_q == ST_IDLE)))
    else $error("draw finished without a result");

  // A clear leaves every row blank.
  a_clear_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.kind == KIND_CLEAR)) |=> (valid_q == '0))
    else $error("rows still valid after clear");

  // A written row is marked valid.
  a_write_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> valid_q[$past(addr_q)])
    else $error("written row not marked valid");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_xor_sprite_row_draw.sv
`timescale 1ns / 1ps
// Self-checking testbench for xor_sprite_row_draw: XOR sprite rows, clears and row reads.
// Depends on xsrd_pkg, xsrd_in_if, xsrd_out_if and the block under test.

module tb_xor_sprite_row_draw;
  import xsrd_pkg::*;

  // Geometry of the instance under test and run control.
  localparam int unsigned FRAME_ROWS  = SCREEN_HEIGHT_DEF;
  localparam int unsigned ITEM_TARGET = 450;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_IDLE    = 17;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned HOLD_AFTER  = 120;
  localparam int unsigned DRAIN_AT    = 300;
  localparam int unsigned TAIL_CYCLES = 20;

  // The fourth kind code has no function; the block must leave its state alone.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // One request as the driver presents it. The drain flag makes the driver hold
  // this request back until every earlier result has come out.
  typedef struct {
    logic [KIND_W-1:0]   kind;
    logic [POS_W-1:0]    x_position;
    logic [POS_W-1:0]    y_position;
    logic [OFFSET_W-1:0] row_offset;
    logic [SPRITE_W-1:0] sprite_bits;
    logic [LINE_W-1:0]   read_line;
    bit                  drain_first;
  } request_t;

  typedef struct {
    logic             collision;
    logic [ROW_W-1:0] row_pixels;
  } result_t;

  logic clk;
  logic rst_n;

  xsrd_in_if  req_if ();
  xsrd_out_if res_if ();

  xor_sprite_row_draw #(
    .SCREEN_HEIGHT(FRAME_ROWS)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .res_o (res_if)
  );

  // Requests waiting to be offered, and results that the predictor has worked
  // out but the block has not yet delivered.
  request_t request_queue[$];
  result_t  awaited_results[$];

  // The predictor's own copy of the frame and of the collision flag.
  logic [ROW_W-1:0] frame_model[FRAME_ROWS];
  logic             collision_model;

  // Handshake flags, set at each rising edge and read at the following falling edge.
  bit          req_fire;
  bit          res_fire;
  int unsigned results_seen;
  int unsigned requests_sent;
  int unsigned error_count;

  // Applies one accepted request to the frame copy and returns the result the
  // block must give for it.
  function automatic result_t predict_xor_draw(input request_t r);
    result_t          res;
    int unsigned      x0;
    int unsigned      target;
    int unsigned      col;
    logic [ROW_W-1:0] mask;
    res.row_pixels = '0;
    mask = '0;
    case (r.kind)
      KIND_CLEAR: begin
        // The frame goes blank; the collision flag is left as it is.
        for (int unsigned i = 0; i < FRAME_ROWS; i++) frame_model[i] = '0;
      end
      KIND_DRAW: begin
        if (r.row_offset < MAX_SPRITE_ROWS) begin
          // Offset zero opens a new sprite, even if its row falls off the bottom.
          if (r.row_offset == 0) collision_model = 1'b0;
          x0     = int'(r.x_position) % SCREEN_WIDTH;
          target = int'(r.y_position) % FRAME_ROWS + int'(r.row_offset);
          if (target < FRAME_ROWS) begin
            // Columns past the right edge are clipped, never wrapped.
            for (int unsigned i = 0; i < SPRITE_W; i++) begin
              col = x0 + i;
              if (col >= SCREEN_WIDTH) break;
              if (r.sprite_bits[SPRITE_W-1-i]) mask[ROW_W-1-col] = 1'b1;
            end
            if ((frame_model[target] & mask) != '0) collision_model = 1'b1;
            frame_model[target] = frame_model[target] ^ mask;
          end
        end
      end
      KIND_READ: begin
        if (r.read_line < FRAME_ROWS) res.row_pixels = frame_model[r.read_line];
      end
      default: begin
      end
    endcase
    res.collision = collision_model;
    return res;
  endfunction

  task automatic add_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] xp,
                             input logic [POS_W-1:0] yp, input logic [OFFSET_W-1:0] offset,
                             input logic [SPRITE_W-1:0] bits, input logic [LINE_W-1:0] line,
                             input bit drain);
    request_t r;
    r.kind        = kind;
    r.x_position  = xp;
    r.y_position  = yp;
    r.row_offset  = offset;
    r.sprite_bits = bits;
    r.read_line   = line;
    r.drain_first = drain;
    request_queue.push_back(r);
  endtask

  // Queues a request of the given kind with every other field random.
  task automatic add_random_request(input logic [KIND_W-1:0] kind, input bit drain);
    add_request(kind, POS_W'($urandom), POS_W'($urandom), OFFSET_W'($urandom),
                SPRITE_W'($urandom), LINE_W'($urandom), drain);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Monitor. Results are checked before the request of the same edge is
  // predicted, because a result can only belong to an earlier request.
  always @(posedge clk) begin
    result_t  exp_res;
    request_t seen;
    req_fire = 1'b0;
    res_fire = 1'b0;
    if (rst_n) begin
      res_fire = res_if.valid && res_if.ready;
      req_fire = req_if.valid && req_if.ready;
      if (res_fire) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          $error("result with no request outstanding: collision %0b, row_pixels %h",
                 res_if.collision, res_if.row_pixels);
          error_count++;
        end else begin
          exp_res = awaited_results.pop_front();
          if (res_if.collision !== exp_res.collision) begin
            $error("collision: expected %0b, got %0b", exp_res.collision, res_if.collision);
            error_count++;
          end
          if (res_if.row_pixels !== exp_res.row_pixels) begin
            $error("row_pixels: expected %h, got %h", exp_res.row_pixels, res_if.row_pixels);
            error_count++;
          end
        end
      end
      if (req_fire) begin
        seen.kind        = req_if.kind;
        seen.x_position  = req_if.x_position;
        seen.y_position  = req_if.y_position;
        seen.row_offset  = req_if.row_offset;
        seen.sprite_bits = req_if.sprite_bits;
        seen.read_line   = req_if.read_line;
        seen.drain_first = 1'b0;
        awaited_results.push_back(predict_xor_draw(seen));
      end
    end
  end

  // Driver. Valid is computed once per falling edge and assigned once, so a
  // back-to-back request keeps valid high without a glitch. One stretch of forty
  // requests in every four, starting with the third, is sent with no gaps at all.
  always @(negedge clk) begin
    logic        nxt_valid;
    request_t    r;
    int unsigned gap_left;
    if (rst_n) begin
      nxt_valid = req_if.valid;
      if (req_if.valid && req_fire) begin
        nxt_valid = 1'b0;
        requests_sent++;
        gap_left = ((requests_sent / 40) % 4 == 2) ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_queue.size() > 0 &&
                     !(request_queue[0].drain_first && awaited_results.size() != 0)) begin
          r = request_queue.pop_front();
          nxt_valid              = 1'b1;
          req_if.kind           <= r.kind;
          req_if.x_position     <= r.x_position;
          req_if.y_position     <= r.y_position;
          req_if.row_offset     <= r.row_offset;
          req_if.sprite_bits    <= r.sprite_bits;
          req_if.read_line      <= r.read_line;
        end
      end
      req_if.valid <= nxt_valid;
    end
  end

  // Receiver. It stalls a random number of cycles after each result, except
  // during stretches with no stalls. Once, well into the run, it refuses
  // results for a long while so that the block backs up onto the request side.
  always @(negedge clk) begin
    int unsigned stall_left;
    int unsigned hold_left;
    bit          hold_done;
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        res_if.ready <= 1'b0;
      end else begin
        if (res_fire)
          stall_left = ((results_seen / 50) % 3 == 1) ? 0 : $urandom_range(0, MAX_IDLE);
        if (stall_left > 0) begin
          stall_left--;
          res_if.ready <= 1'b0;
        end else begin
          res_if.ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: the run is abandoned if it takes far longer than any correct run.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    int unsigned count;
    int unsigned pick;
    int unsigned rows;
    logic [POS_W-1:0] sx;
    logic [POS_W-1:0] sy;
    bit drain_placed;

    req_if.valid       = 1'b0;
    req_if.kind        = KIND_CLEAR;
    req_if.x_position  = '0;
    req_if.y_position  = '0;
    req_if.row_offset  = '0;
    req_if.sprite_bits = '0;
    req_if.read_line   = '0;
    res_if.ready       = 1'b0;
    for (int unsigned i = 0; i < FRAME_ROWS; i++) frame_model[i] = '0;
    collision_model = 1'b0;
    results_seen    = 0;
    requests_sent   = 0;
    error_count     = 0;
    rst_n           = 1'b0;

    // Directed part. Reads of a blank frame at both ends.
    add_request(KIND_READ, 8'h00, 8'h00, 4'h0, 8'h00, 5'd0, 1'b0);
    add_request(KIND_READ, 8'hFF, 8'hFF, 4'hF, 8'hFF, 5'd31, 1'b0);
    // A full byte at the origin, then again on top of itself: the second
    // erases lit pixels and raises the collision flag.
    add_request(KIND_DRAW, 8'h00, 8'h00, 4'h0, 8'hFF, 5'd0, 1'b0);
    add_request(KIND_DRAW, 8'h00, 8'h00, 4'h0, 8'hFF, 5'd0, 1'b0);
    add_request(KIND_READ, 8'h00, 8'h00, 4'h0, 8'h00, 5'd0, 1'b0);
    // Clear keeps the collision flag as it is.
    add_request(KIND_DRAW, 8'd64, 8'd32, 4'h0, 8'hA5, 5'd0, 1'b0);
    add_request(KIND_DRAW, 8'd64, 8'd32, 4'h1, 8'h5A, 5'd0, 1'b0);
    add_request(KIND_DRAW, 8'd0, 8'd0, 4'h0, 8'h81, 5'd0, 1'b0);
    add_request(KIND_CLEAR, 8'hFF, 8'hFF, 4'hF, 8'hFF, 5'd31, 1'b0);
    add_request(KIND_READ, 8'h00, 8'h00, 4'h0, 8'h00, 5'd0, 1'b0);
    // Right edge: columns past 63 are clipped; the x of 255 wraps to column 63.
    add_request(KIND_DRAW, 8'd60, 8'd31, 4'h0, 8'hFF, 5'd0, 1'b0);
    add_request(KIND_DRAW, 8'hFF, 8'hFF, 4'h0, 8'hFF, 5'd0, 1'b0);
    add_request(KIND_READ, 8'h00, 8'h00, 4'h0, 8'h00, 5'd31, 1'b0);
    // Rows past the bottom are skipped. A nonzero offset keeps the flag, while
    // offset zero clears it even when its row is on screen but empty.
    add_request(KIND_DRAW, 8'hFF, 8'hFF, 4'h1, 8'hFF, 5'd0, 1'b0);
    add_request(KIND_DRAW, 8'd10, 8'd20, 4'hF, 8'hFF, 5'd0, 1'b0);
    add_request(KIND_DRAW, 8'd10, 8'd0, 4'hF, 8'hC3, 5'd0, 1'b0);
    add_request(KIND_READ, 8'h00, 8'h00, 4'h0, 8'h00, 5'd15, 1'b0);
    add_request(KIND_DRAW, 8'd3, 8'd31, 4'h0, 8'h00, 5'd0, 1'b0);
    // The unused kind changes nothing and returns zero pixels.
    add_request(KIND_UNUSED, 8'hFF, 8'h00, 4'h0, 8'hFF, 5'd0, 1'b0);
    add_request(KIND_UNUSED, 8'h00, 8'hFF, 4'hF, 8'h00, 5'd31, 1'b0);
    add_request(KIND_READ, 8'h00, 8'h00, 4'h0, 8'h00, 5'd31, 1'b0);
    count = request_queue.size();

    // Random part. Most of it is whole sprites of one to fifteen rows with
    // random content, so collisions and clipping occur often; the rest is
    // reads, stray rows, clears and the unused kind.
    drain_placed = 1'b0;
    while (count < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (!drain_placed && count >= DRAIN_AT) begin
        // The sender pauses here until the block has delivered everything.
        drain_placed = 1'b1;
        add_random_request(KIND_READ, 1'b1);
        count++;
      end else if (pick < 60) begin
        sx   = POS_W'($urandom);
        sy   = POS_W'($urandom);
        rows = $urandom_range(1, MAX_SPRITE_ROWS - 1);
        for (int unsigned r = 0; r < rows; r++) begin
          add_request(KIND_DRAW, sx, sy, OFFSET_W'(r), SPRITE_W'($urandom), LINE_W'($urandom),
                      1'b0);
          count++;
        end
      end else if (pick < 80) begin
        add_random_request(KIND_READ, 1'b0);
        count++;
      end else if (pick < 92) begin
        add_random_request(KIND_DRAW, 1'b0);
        count++;
      end else if (pick < 96) begin
        add_random_request(KIND_UNUSED, 1'b0);
        count++;
      end else begin
        add_random_request(KIND_CLEAR, 1'b0);
        count++;
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Wait for every request to be taken and every result to come out, then
    // TAIL_CYCLES more to catch anything unexpected.
    while (request_queue.size() != 0 || req_if.valid) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: xor_sprite_row_draw.f
hdl/xsrd_pkg.sv
hdl/xsrd_in_if.sv
hdl/xsrd_out_if.sv
hdl/xsrd_ram.sv
hdl/xsrd_lane.sv
hdl/xsrd_merge.sv
hdl/xor_sprite_row_draw.sv
verif/tb_xor_sprite_row_draw.sv
